[rtl/core/hilbert_index_to_xy_defines.svh]
// Assertion macros shared by the Hilbert index-to-coordinate converter.
`ifndef HILBERT_INDEX_TO_XY_DEFINES_SVH
`define HILBERT_INDEX_TO_XY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HBX_ASSERT_IMPLY(label, clk, rst, cond, consq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (consq)) \
      else $error("Hilbert converter check failed.");

// Next-cycle implication, checked outside reset.
`define HBX_ASSERT_NEXT(label, clk, rst, cond, consq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (consq)) \
      else $error("Hilbert converter check failed.");

`endif

[rtl/core/hbx_pkg.sv]
// Types and constants for the Hilbert index-to-coordinate converter.
package hbx_pkg;

   localparam int MaxOrder   = 8;
   localparam int IndexWidth = 16;
   localparam int CoordWidth = 8;
   localparam int OrderWidth = 4;

   localparam logic [OrderWidth-1:0] OrderReset = OrderWidth'(MaxOrder);

   localparam logic [1:0] DirRight = 2'd0;
   localparam logic [1:0] DirDown  = 2'd1;
   localparam logic [1:0] DirLeft  = 2'd2;
   localparam logic [1:0] DirUp    = 2'd3;

   typedef struct packed {
      logic [IndexWidth-1:0] index;
      logic [OrderWidth-1:0] order;
      logic                  out_of_range;
      logic [CoordWidth-1:0] x;
      logic [CoordWidth-1:0] y;
      logic [1:0]            heading;
      logic                  turn_neg;
   } word_type;

endpackage

[rtl/core/hbx_cell.sv]
// One level of the Hilbert descent: picks the quadrant and moves the cell origin.
module hbx_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [hbx_pkg::OrderWidth-1:0] level,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  hbx_pkg::word_type            in_word,
   output logic                         out_valid,
   input  logic                         out_ready,
   output hbx_pkg::word_type            out_word
);
   import hbx_pkg::*;

   logic                  valid_ff, valid_in;
   word_type              word_ff, word_in;
   logic                  active;
   logic [1:0]            quad;
   logic [4:0]            shamt;
   logic [CoordWidth-1:0] half, amt_a, amt_b;
   logic [1:0]            dir_ht, step_t;
   logic [CoordWidth-1:0] x_a, y_a, x_b, y_b;

   function automatic logic [2*CoordWidth-1:0] move(input logic [CoordWidth-1:0] px,
                                                    input logic [CoordWidth-1:0] py,
                                                    input logic [1:0] dir,
                                                    input logic [CoordWidth-1:0] amt);
      logic [CoordWidth-1:0] nx, ny;
      nx = px;
      ny = py;
      unique case (dir)
         DirRight: nx = px + amt;
         DirDown:  ny = py - amt;
         DirLeft:  nx = px - amt;
         DirUp:    ny = py + amt;
         default:  nx = px;
      endcase
      return {nx, ny};
   endfunction

   always_comb begin
      active = (level != '0) && (level <= in_word.order);
      shamt  = {level - OrderWidth'(1), 1'b0};
      quad   = 2'(in_word.index >> shamt);
      half   = CoordWidth'(1) << (level - OrderWidth'(1));
      step_t = in_word.turn_neg ? 2'd3 : 2'd1;
      dir_ht = in_word.heading + step_t;
      amt_a  = '0;
      amt_b  = '0;
      word_in = in_word;
      case (quad)
         2'd0: begin
            word_in.heading  = dir_ht;
            word_in.turn_neg = ~in_word.turn_neg;
         end
         2'd1: amt_a = half;
         2'd2: begin
            amt_a = half;
            amt_b = half;
         end
         default: begin
            amt_a = half - CoordWidth'(1);
            amt_b = (half << 1) - CoordWidth'(1);
            word_in.heading  = in_word.heading - step_t;
            word_in.turn_neg = ~in_word.turn_neg;
         end
      endcase
      {x_a, y_a} = move(in_word.x, in_word.y, in_word.heading, amt_a);
      {x_b, y_b} = move(x_a, y_a, dir_ht, amt_b);
      word_in.x = x_b;
      word_in.y = y_b;
      if (!active) begin
         word_in = in_word;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

[rtl/core/hilbert_index_to_xy.sv]
// Top level of the Hilbert curve index-to-coordinate converter.
// Converts a position along a Hilbert curve on a 2^order square grid into the cell's column and
// row. A row of eight cells, one per curve level, carries each word; a new word may enter every
// cycle while req_ready is high. Each cell stalls only when it is full and the cell after it
// cannot take its word, so bubbles close up behind a waiting result. An index not below
// 4^order returns zero coordinates with out_of_range set. The order register takes effect for
// words accepted after it is written and saturates at eight.
`include "hilbert_index_to_xy_defines.svh"

module hilbert_index_to_xy (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hbx_pkg::OrderWidth-1:0] csr_curve_order,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [hbx_pkg::IndexWidth-1:0] req_cell_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [hbx_pkg::CoordWidth-1:0] rsp_x_coord,
   output logic [hbx_pkg::CoordWidth-1:0] rsp_y_coord,
   output logic                           rsp_out_of_range
);
   import hbx_pkg::*;

   logic [OrderWidth-1:0] curve_order_ff, curve_order_in;
   logic [OrderWidth-1:0] order_eff;
   logic                  valid_chain [0:MaxOrder];
   logic                  ready_chain [0:MaxOrder];
   word_type              word_chain  [0:MaxOrder];
   word_type              last_word;

   assign csr_ready      = 1'b1;
   assign curve_order_in = (csr_valid && csr_ready) ? csr_curve_order : curve_order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_order_ff <= OrderReset;
      end else begin
         curve_order_ff <= curve_order_in;
      end
   end

   always_comb begin
      order_eff = (curve_order_ff > OrderWidth'(MaxOrder)) ? OrderWidth'(MaxOrder)
                                                          : curve_order_ff;
      word_chain[0].index        = req_cell_index;
      word_chain[0].order        = order_eff;
      word_chain[0].out_of_range = (req_cell_index >> {order_eff, 1'b0}) != '0;
      word_chain[0].x            = '0;
      word_chain[0].y            = '0;
      word_chain[0].heading      = DirUp;
      word_chain[0].turn_neg     = 1'b0;
   end

   assign valid_chain[0] = req_valid;
   assign req_ready      = ready_chain[0];

   for (genvar j = 0; j < MaxOrder; j++) begin : g_cell
      hbx_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .level     (OrderWidth'(MaxOrder - j)),
         .in_valid  (valid_chain[j]),
         .in_ready  (ready_chain[j]),
         .in_word   (word_chain[j]),
         .out_valid (valid_chain[j+1]),
         .out_ready (ready_chain[j+1]),
         .out_word  (word_chain[j+1])
      );
   end

   assign last_word             = word_chain[MaxOrder];
   assign ready_chain[MaxOrder] = rsp_ready;
   assign rsp_valid             = valid_chain[MaxOrder];
   assign rsp_out_of_range      = last_word.out_of_range;
   assign rsp_x_coord           = last_word.out_of_range ? '0 : last_word.x;
   assign rsp_y_coord           = last_word.out_of_range ? '0 : last_word.y;

   `HBX_ASSERT_IMPLY(a_stall_needs_result, clock, reset, !req_ready, rsp_valid)
   `HBX_ASSERT_IMPLY(a_x_in_grid, clock, reset, rsp_valid && !rsp_out_of_range,
      (({8'b0, rsp_x_coord} >> last_word.order) == 16'd0))
   `HBX_ASSERT_NEXT(a_held_result_stays, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(last_word))

endmodule
